// File: design/pwis_pkg.sv
package pwis_pkg;

  // settle time in whole seconds before the drive is held at zero
  localparam int SETTLE_SECONDS = 5;

  // serial multiplier: gain bits consumed one per cycle
  localparam int GAIN_W = 16;
  localparam int ACC_W  = 49;

  // restoring divider for the integral clamp bound
  localparam int DIV_W  = 31;

  typedef enum logic [2:0] {
    REG_SETPOINT  = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_TOLERANCE = 3'd4,
    REG_RANGE     = 3'd5,
    REG_LIMIT     = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_P_CHK,
    ST_MUL_D,
    ST_INT_UPD,
    ST_I_LOAD,
    ST_MUL_I,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [15:0] measured;
    logic        [31:0] now_seconds;
  } pwis_in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               held_zero;
  } pwis_out_t;

endpackage

// File: design/pid_with_integral_separation.sv
// one item at a time: a new input is accepted only in the idle state
// the three products run through one shift-add multiplier, one gain bit per cycle; the
// clamp bound divider runs alongside the p and d products
// the result register frees the input side: a new item is taken while a result waits
// reset (synchronous, active low) restores register defaults, clears the loop state
// and marks the next sample as the first one
module pid_with_integral_separation import pwis_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pwis_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pwis_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [15:0] setpoint_r;
  logic [15:0] gain_p_r;
  logic [15:0] gain_i_r;
  logic [15:0] gain_d_r;
  logic [15:0] tol_r;
  logic [30:0] range_r;
  logic [30:0] limit_r;

  // loop state carried between samples
  state_t      state_r, state_nxt;
  logic        first_sample_r;
  logic [16:0] previous_error_r;
  logic [31:0] error_sum_r;
  logic [31:0] settled_r;
  logic [31:0] last_seconds_r;

  // per item working registers
  logic [16:0]      err_r;
  logic [17:0]      diff_r;
  logic [31:0]      dt_r;
  logic             inside_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] mcand_r;
  logic [GAIN_W-1:0] mplier_r;
  logic [3:0]       bit_cnt_r;

  // clamp bound divider
  logic [14:0]      div_rem_r;
  logic [DIV_W-1:0] div_quo_r;
  logic [4:0]       div_cnt_r;
  logic             div_busy_r;

  // result register
  logic      out_valid_r;
  pwis_out_t out_data_r;

  logic in_fire;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // error, derivative difference and elapsed time at acceptance
  logic [16:0] err_in;
  logic [17:0] diff_in;
  logic [31:0] dt_in;

  assign err_in  = {setpoint_r[15], setpoint_r} - {in_data.measured[15], in_data.measured};
  // first sample: derivative and elapsed time are taken as zero
  assign diff_in = first_sample_r ? 18'd0 :
                   ({err_in[16], err_in} - {previous_error_r[16], previous_error_r});
  assign dt_in   = first_sample_r ? 32'd0 : (in_data.now_seconds - last_seconds_r);

  // shift-add multiplier step, lsb first; the sign bit of the gain has negative weight
  logic [ACC_W-1:0] mul_add;
  logic [ACC_W-1:0] acc_step;
  logic             mul_last;

  assign mul_last = (bit_cnt_r == 4'd15);
  assign mul_add  = mplier_r[0] ? mcand_r : '0;
  assign acc_step = mul_last ? (acc_r - mul_add) : (acc_r + mul_add);

  // integral separation test on the finished proportional term
  logic [31:0] p_mag;
  logic        sep_now;

  assign p_mag   = acc_r[31] ? (32'd0 - acc_r[31:0]) : acc_r[31:0];
  assign sep_now = (p_mag >= {1'b0, range_r});

  // error accumulation, saturated to 32 bits
  logic [32:0] esum_ext;
  logic [31:0] esum_sat;

  assign esum_ext = {error_sum_r[31], error_sum_r} + {{16{err_r[16]}}, err_r};
  assign esum_sat = (esum_ext[32] != esum_ext[31]) ?
                    (esum_ext[32] ? 32'h8000_0000 : 32'h7fff_ffff) : esum_ext[31:0];

  // settle band test
  logic [16:0] err_mag;
  logic        inside_now;

  assign err_mag    = err_r[16] ? (17'd0 - err_r) : err_r;
  assign inside_now = (err_mag <= {1'b0, tol_r});

  // clamp: |sum| * gain_i > limit is the same as |sum| > floor(limit / gain_i)
  logic [31:0] es_mag;
  logic        gain_i_pos;
  logic        clamp;
  logic [31:0] clamp_val;

  assign es_mag     = error_sum_r[31] ? (32'd0 - error_sum_r) : error_sum_r;
  assign gain_i_pos = !gain_i_r[15] && (gain_i_r != 16'd0);
  assign clamp      = gain_i_pos && (es_mag > {1'b0, div_quo_r});
  assign clamp_val  = error_sum_r[31] ? (32'd0 - {1'b0, div_quo_r}) : {1'b0, div_quo_r};

  // restoring divider step, one quotient bit per cycle
  logic [15:0] div_shift;
  logic [16:0] div_trial;

  assign div_shift = {div_rem_r, div_quo_r[DIV_W-1]};
  assign div_trial = {1'b0, div_shift} - {2'b00, gain_i_r[14:0]};

  // final sum saturated to the drive range
  logic [ACC_W-32:0] acc_hi;
  logic [31:0]       drive_sat;
  logic              held;
  logic [32:0]       settle_sum;
  logic [31:0]       settled_upd;

  assign acc_hi    = acc_r[ACC_W-1:31];
  assign drive_sat = ((&acc_hi) || !(|acc_hi)) ? acc_r[31:0] :
                     (acc_r[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff);
  // hold decision looks at the settle time before this sample adds to it
  assign held      = inside_r && (settled_r >= 32'(SETTLE_SECONDS));
  assign settle_sum  = {1'b0, settled_r} + {1'b0, dt_r};
  assign settled_upd = settle_sum[32] ? 32'hffff_ffff : settle_sum[31:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        if (mul_last) begin
          state_nxt = ST_P_CHK;
        end
      end
      ST_P_CHK: begin
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        if (mul_last) begin
          state_nxt = ST_INT_UPD;
        end
      end
      ST_INT_UPD: begin
        // wait for the clamp bound
        if (!div_busy_r) begin
          state_nxt = ST_I_LOAD;
        end
      end
      ST_I_LOAD: begin
        state_nxt = ST_MUL_I;
      end
      ST_MUL_I: begin
        if (mul_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // configuration writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      gain_p_r   <= '0;
      gain_i_r   <= '0;
      gain_d_r   <= '0;
      tol_r      <= '0;
      range_r    <= 31'd65535;
      limit_r    <= 31'd65535;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SETPOINT:  setpoint_r <= cfg_data[15:0];
        REG_GAIN_P:    gain_p_r   <= cfg_data[15:0];
        REG_GAIN_I:    gain_i_r   <= cfg_data[15:0];
        REG_GAIN_D:    gain_d_r   <= cfg_data[15:0];
        REG_TOLERANCE: tol_r      <= cfg_data[15:0];
        REG_RANGE:     range_r    <= cfg_data[30:0];
        REG_LIMIT:     limit_r    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sample_r   <= 1'b1;
      previous_error_r <= '0;
      error_sum_r      <= '0;
      settled_r        <= '0;
      last_seconds_r   <= '0;
    end else begin
      if (in_fire) begin
        first_sample_r   <= 1'b0;
        previous_error_r <= err_in;
        last_seconds_r   <= in_data.now_seconds;
        // first sample starts the integral from zero
        if (first_sample_r) begin
          error_sum_r <= '0;
        end
      end
      if (state_r == ST_P_CHK) begin
        error_sum_r <= sep_now ? 32'd0 : esum_sat;
      end
      if ((state_r == ST_INT_UPD) && !div_busy_r && clamp) begin
        error_sum_r <= clamp_val;
      end
      if ((state_r == ST_FINISH) && out_free) begin
        settled_r <= inside_r ? settled_upd : 32'd0;
      end
    end
  end

  // multiplier and per item datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r     <= err_in;
      diff_r    <= diff_in;
      dt_r      <= dt_in;
      acc_r     <= '0;
      mcand_r   <= {{(ACC_W-17){err_in[16]}}, err_in};
      mplier_r  <= gain_p_r;
      bit_cnt_r <= '0;
    end else begin
      case (state_r)
        ST_MUL_P, ST_MUL_D, ST_MUL_I: begin
          acc_r     <= acc_step;
          mcand_r   <= {mcand_r[ACC_W-2:0], 1'b0};
          mplier_r  <= {1'b0, mplier_r[GAIN_W-1:1]};
          bit_cnt_r <= bit_cnt_r + 4'd1;
        end
        ST_P_CHK: begin
          // keep p in the accumulator, add d onto it
          inside_r  <= inside_now;
          mcand_r   <= {{(ACC_W-18){diff_r[17]}}, diff_r};
          mplier_r  <= gain_d_r;
          bit_cnt_r <= '0;
        end
        ST_I_LOAD: begin
          mcand_r   <= {{(ACC_W-32){error_sum_r[31]}}, error_sum_r};
          mplier_r  <= gain_i_r;
          bit_cnt_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // clamp bound divider: limit / gain_i
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (in_fire) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && (div_cnt_r == 5'(DIV_W - 1))) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      div_rem_r <= '0;
      div_quo_r <= limit_r;
      div_cnt_r <= '0;
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r + 5'd1;
      if (!div_trial[16]) begin
        div_rem_r <= div_trial[14:0];
        div_quo_r <= {div_quo_r[DIV_W-2:0], 1'b1};
      end else begin
        div_rem_r <= div_shift[14:0];
        div_quo_r <= {div_quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FINISH) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FINISH) && out_free) begin
      out_data_r.drive     <= held ? 32'sd0 : drive_sat;
      out_data_r.held_zero <= held;
    end
  end

endmodule

// File: design/pwis_chk.sv
module pwis_chk import pwis_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input pwis_out_t out_data
);

  // a held result always carries a zero drive
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.held_zero) |-> (out_data.drive == 32'sd0))
    else $error("held result with nonzero drive");

  // one item at a time: busy right after an input transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  // a result never appears in the cycle after an input transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind pid_with_integral_separation pwis_chk u_pwis_chk (.*);
